[sv/lgp_pkg.sv]
package lgp_pkg;

    // color channels per pixel, red first
    localparam int NUM_CH = 4;
    // quotient bits of the fade divide
    localparam int QW = 8;
    // remainder / numerator width: |b - a| * (offset - lo) stays below 2**15
    localparam int NUM_W = 15;
    // window span hi - lo stays below 2**7
    localparam int DEN_W = 7;

    localparam int CFG_W = 32;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_SEG_BEGIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SEG_END     = 3'd1;
    localparam logic [IDX_W-1:0] REG_COLOR_A     = 3'd2;
    localparam logic [IDX_W-1:0] REG_COLOR_B     = 3'd3;
    localparam logic [IDX_W-1:0] REG_FADE_CENTER = 3'd4;
    localparam logic [IDX_W-1:0] REG_FADE_WIDTH  = 3'd5;

    typedef struct packed {
        logic [5:0]  seg_begin;
        logic [6:0]  seg_end;
        logic [31:0] color_a;
        logic [31:0] color_b;
        logic [7:0]  fade_center;
        logic [7:0]  fade_width;
    } lgp_cfg_t;

    // one color channel on its way through the divider
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic [QW-1:0]    base;
    } lgp_lane_t;

    // channel 0 is red at 31:24, channel 3 is white at 7:0
    function automatic logic [7:0] chan_of(input logic [31:0] color, input int ch);
        logic [7:0] val;
        val = 8'd0;
        case (ch)
            0:       val = color[31:24];
            1:       val = color[23:16];
            2:       val = color[15:8];
            3:       val = color[7:0];
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

[sv/lgp_front.sv]
module lgp_front #(
    parameter int MAX_LEDS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  lgp_pkg::lgp_cfg_t   cfg,
    input  logic                in_valid,
    input  logic [5:0]          offset,
    output logic                lane_valid,
    output logic [5:0]          lane_index,
    output lgp_pkg::lgp_lane_t  lanes [lgp_pkg::NUM_CH]
);

    localparam int NCH = lgp_pkg::NUM_CH;

    // stage 1: segment bounds
    logic signed [7:0] steps_s;
    logic [6:0]        abs_sum;
    logic              v1_next;
    logic              v1_reg;
    logic [5:0]        off1_reg;
    logic [6:0]        steps1_reg;
    logic [5:0]        idx1_reg;

    // stage 2: window products
    logic [8:0]         center2;
    logic signed [10:0] span_lo;
    logic [9:0]         span_hi;
    logic signed [17:0] plo_next;
    logic [16:0]        phi_next;
    logic               v2_reg;
    logic [5:0]         off2_reg;
    logic [6:0]         steps2_reg;
    logic [5:0]         idx2_reg;
    logic signed [17:0] plo2_reg;
    logic [16:0]        phi2_reg;

    // stage 3: rounding and clamp
    logic [17:0]       lo_mag;
    logic [17:0]       lo_rnd;
    logic [16:0]       hi_rnd;
    logic signed [7:0] lo_next;
    logic [6:0]        hi_next;
    logic              v3_reg;
    logic [5:0]        off3_reg;
    logic [5:0]        idx3_reg;
    logic signed [7:0] lo3_reg;
    logic [6:0]        hi3_reg;

    // stage 4: region select and channel deltas
    logic              selb_next;
    logic              fade_next;
    logic [7:0]        t_wide;
    logic [7:0]        den_wide;
    logic [8:0]        delta [NCH];
    logic [8:0]        delta_neg [NCH];
    logic [7:0]        mag_next [NCH];
    logic              v4_reg;
    logic [5:0]        idx4_reg;
    logic              selb4_reg;
    logic              fade4_reg;
    logic [6:0]        t4_reg;
    logic [6:0]        den4_reg;
    logic [7:0]        mag4_reg [NCH];
    logic              neg4_reg [NCH];

    // stage 5: fade numerator
    lgp_pkg::lgp_lane_t lane_next [NCH];
    logic               v5_reg;
    logic [5:0]         idx5_reg;
    lgp_pkg::lgp_lane_t lane5_reg [NCH];

    always_comb
    begin
        steps_s = $signed({1'b0, cfg.seg_end}) - $signed({2'b00, cfg.seg_begin});
        abs_sum = {1'b0, cfg.seg_begin} + {1'b0, offset};
        v1_next = in_valid && (steps_s > 8'sd0)
                  && ($signed({2'b00, offset}) < steps_s)
                  && ({25'd0, abs_sum} < 32'(MAX_LEDS));
    end

    always_comb
    begin
        center2  = {cfg.fade_center, 1'b0};
        span_lo  = $signed({2'b00, center2}) - $signed({3'b000, cfg.fade_width});
        span_hi  = {1'b0, center2} + {2'b00, cfg.fade_width};
        plo_next = $signed({11'd0, steps1_reg}) * $signed({{7{span_lo[10]}}, span_lo});
        phi_next = {10'd0, steps1_reg} * {7'd0, span_hi};
    end

    // round half away from zero, then clamp the upper edge to the segment
    always_comb
    begin
        lo_mag = plo2_reg[17] ? 18'(-plo2_reg) : plo2_reg;
        lo_rnd = (lo_mag + 18'd256) >> 9;
        hi_rnd = (phi2_reg + 17'd256) >> 9;
        lo_next = plo2_reg[17] ? (8'sd0 - $signed({1'b0, lo_rnd[6:0]}))
                               : $signed({1'b0, lo_rnd[6:0]});
        if (hi_rnd[7:0] > {1'b0, steps2_reg})
        begin
            hi_next = steps2_reg;
        end
        else
        begin
            hi_next = hi_rnd[6:0];
        end
    end

    always_comb
    begin
        selb_next = {2'b00, off3_reg} >= {1'b0, hi3_reg};
        fade_next = !selb_next && ($signed({2'b00, off3_reg}) > lo3_reg);
        t_wide    = {2'b00, off3_reg} - lo3_reg;
        den_wide  = {1'b0, hi3_reg} - lo3_reg;
        for (int ch = 0; ch < NCH; ch++)
        begin
            delta[ch]     = {1'b0, lgp_pkg::chan_of(cfg.color_b, ch)}
                            - {1'b0, lgp_pkg::chan_of(cfg.color_a, ch)};
            delta_neg[ch] = 9'd0 - delta[ch];
            mag_next[ch]  = delta[ch][8] ? delta_neg[ch][7:0] : delta[ch][7:0];
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            lane_next[ch].num  = fade4_reg ? ({7'd0, mag4_reg[ch]} * {8'd0, t4_reg})
                                           : '0;
            lane_next[ch].den  = fade4_reg ? den4_reg : 7'd1;
            lane_next[ch].neg  = fade4_reg && neg4_reg[ch];
            lane_next[ch].base = selb4_reg ? lgp_pkg::chan_of(cfg.color_b, ch)
                                           : lgp_pkg::chan_of(cfg.color_a, ch);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off1_reg   <= offset;
            steps1_reg <= steps_s[6:0];
            idx1_reg   <= abs_sum[5:0];

            off2_reg   <= off1_reg;
            steps2_reg <= steps1_reg;
            idx2_reg   <= idx1_reg;
            plo2_reg   <= plo_next;
            phi2_reg   <= phi_next;

            off3_reg   <= off2_reg;
            idx3_reg   <= idx2_reg;
            lo3_reg    <= lo_next;
            hi3_reg    <= hi_next;

            idx4_reg   <= idx3_reg;
            selb4_reg  <= selb_next;
            fade4_reg  <= fade_next;
            t4_reg     <= t_wide[6:0];
            den4_reg   <= den_wide[6:0];
            for (int ch = 0; ch < NCH; ch++)
            begin
                mag4_reg[ch] <= mag_next[ch];
                neg4_reg[ch] <= delta[ch][8];
            end

            idx5_reg <= idx4_reg;
            for (int ch = 0; ch < NCH; ch++)
            begin
                lane5_reg[ch] <= lane_next[ch];
            end
        end
    end

    assign lane_valid = v5_reg;
    assign lane_index = idx5_reg;

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            lanes[ch] = lane5_reg[ch];
        end
    end

endmodule

[sv/lgp_div.sv]
module lgp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [5:0]                  in_index,
    input  lgp_pkg::lgp_lane_t          lanes_in [lgp_pkg::NUM_CH],
    output logic                        out_valid,
    output logic [5:0]                  out_index,
    output logic [lgp_pkg::QW-1:0]      q_out [lgp_pkg::NUM_CH],
    output logic [lgp_pkg::QW-1:0]      base_out [lgp_pkg::NUM_CH],
    output logic                        neg_out [lgp_pkg::NUM_CH]
);

    localparam int NCH = lgp_pkg::NUM_CH;
    localparam int QW  = lgp_pkg::QW;
    localparam int NW  = lgp_pkg::NUM_W;
    localparam int DW  = lgp_pkg::DEN_W;

    // one restoring step per stage, quotient msb first; num carries the remainder
    logic               valid_reg [QW];
    logic [5:0]         index_reg [QW];
    lgp_pkg::lgp_lane_t lane_reg  [QW][NCH];
    logic [QW-1:0]      q_reg     [QW][NCH];

    lgp_pkg::lgp_lane_t lane_src  [QW][NCH];
    logic [QW-1:0]      q_src     [QW][NCH];
    lgp_pkg::lgp_lane_t lane_next [QW][NCH];
    logic [QW-1:0]      q_next    [QW][NCH];
    logic [NW-1:0]      den_shift [QW][NCH];
    logic               take      [QW][NCH];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                if (k == 0)
                begin
                    lane_src[k][ch] = lanes_in[ch];
                    q_src[k][ch]    = '0;
                end
                else
                begin
                    lane_src[k][ch] = lane_reg[k-1][ch];
                    q_src[k][ch]    = q_reg[k-1][ch];
                end
                den_shift[k][ch] = {{(NW-DW){1'b0}}, lane_src[k][ch].den} << (QW-1-k);
                take[k][ch]      = lane_src[k][ch].num >= den_shift[k][ch];
                lane_next[k][ch] = lane_src[k][ch];
                if (take[k][ch])
                begin
                    lane_next[k][ch].num = lane_src[k][ch].num - den_shift[k][ch];
                end
                q_next[k][ch] = {q_src[k][ch][QW-2:0], take[k][ch]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < QW; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            index_reg[0] <= in_index;
            for (int k = 1; k < QW; k++)
            begin
                index_reg[k] <= index_reg[k-1];
            end
            for (int k = 0; k < QW; k++)
            begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    lane_reg[k][ch] <= lane_next[k][ch];
                    q_reg[k][ch]    <= q_next[k][ch];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_index = index_reg[QW-1];

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            q_out[ch]    = q_reg[QW-1][ch];
            base_out[ch] = lane_reg[QW-1][ch].base;
            neg_out[ch]  = lane_reg[QW-1][ch].neg;
        end
    end

endmodule

[sv/led_segment_gradient_pixel_core.sv]
// RGBW gradient pixel for one segment of an LED strip.
// pixel channel: pixel_valid / pixel_stall carry one word, pixel_offset, counted
// from seg_begin. result channel: result_valid / result_stall carry led_index
// (seg_begin + offset) and the red, green, blue and white bytes of the pixel.
// an offset at or past the segment end, an empty segment, or an index at or
// past MAX_LEDS gives no result word; the word just drops out of the pipe.
// configuration: cfg_we writes cfg_data into register cfg_index (0 seg_begin,
// 1 seg_end, 2 color_a, 3 color_b, 4 fade_center, 5 fade_width); write only
// while no word is in flight. unknown indexes are ignored.
// from accept to result a word passes 5 stages for segment bounds, fade window,
// rounding, region select and numerator multiply, 8 stages of the restoring
// divider (one quotient bit per stage, four channels side by side) and the
// output register. the pipe takes one word per cycle while no waiting result is stalled.
// when result_stall holds a waiting result, the whole pipe freezes and
// pixel_stall rises in the same cycle; nothing is lost or repeated.
// reset clears all valid bits and loads the register defaults
// (segment 0..64, colors 0, center 128, width 32).
module led_segment_gradient_pixel_core #(
    parameter int MAX_LEDS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [lgp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lgp_pkg::CFG_W-1:0]   cfg_data,

    input  logic                        pixel_valid,
    output logic                        pixel_stall,
    input  logic [5:0]                  pixel_offset,

    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [5:0]                  led_index,
    output logic [7:0]                  red_out,
    output logic [7:0]                  green_out,
    output logic [7:0]                  blue_out,
    output logic [7:0]                  white_out
);

    localparam int NCH = lgp_pkg::NUM_CH;
    localparam int QW  = lgp_pkg::QW;

    lgp_pkg::lgp_cfg_t  cfg_reg;
    logic               en;

    logic               lane_valid;
    logic [5:0]         lane_index;
    lgp_pkg::lgp_lane_t lanes [NCH];

    logic               div_valid;
    logic [5:0]         div_index;
    logic [QW-1:0]      div_q    [NCH];
    logic [QW-1:0]      div_base [NCH];
    logic               div_neg  [NCH];

    logic [7:0]         color_next [NCH];
    logic               res_valid_reg;
    logic [5:0]         res_index_reg;
    logic [7:0]         color_reg [NCH];

    // one freeze for the whole pipe while a result waits
    assign en          = !(res_valid_reg && result_stall);
    assign pixel_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_begin   <= 6'd0;
            cfg_reg.seg_end     <= 7'd64;
            cfg_reg.color_a     <= 32'd0;
            cfg_reg.color_b     <= 32'd0;
            cfg_reg.fade_center <= 8'd128;
            cfg_reg.fade_width  <= 8'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lgp_pkg::REG_SEG_BEGIN:   cfg_reg.seg_begin   <= cfg_data[5:0];
                lgp_pkg::REG_SEG_END:     cfg_reg.seg_end     <= cfg_data[6:0];
                lgp_pkg::REG_COLOR_A:     cfg_reg.color_a     <= cfg_data[31:0];
                lgp_pkg::REG_COLOR_B:     cfg_reg.color_b     <= cfg_data[31:0];
                lgp_pkg::REG_FADE_CENTER: cfg_reg.fade_center <= cfg_data[7:0];
                lgp_pkg::REG_FADE_WIDTH:  cfg_reg.fade_width  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    lgp_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg_reg),
        .in_valid   (pixel_valid),
        .offset     (pixel_offset),
        .lane_valid (lane_valid),
        .lane_index (lane_index),
        .lanes      (lanes)
    );

    lgp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lane_valid),
        .in_index  (lane_index),
        .lanes_in  (lanes),
        .out_valid (div_valid),
        .out_index (div_index),
        .q_out     (div_q),
        .base_out  (div_base),
        .neg_out   (div_neg)
    );

    // quotient is a magnitude; the sign of b - a picks add or subtract
    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            color_next[ch] = div_neg[ch] ? (div_base[ch] - div_q[ch])
                                         : (div_base[ch] + div_q[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_index_reg <= div_index;
            for (int ch = 0; ch < NCH; ch++)
            begin
                color_reg[ch] <= color_next[ch];
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign led_index    = res_index_reg;
    assign red_out      = color_reg[0];
    assign green_out    = color_reg[1];
    assign blue_out     = color_reg[2];
    assign white_out    = color_reg[3];

    // a receiver that is not stalling never backs up the pixel side
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !pixel_stall)
        else $error("pixel_stall high while result side is ready");

    // a result word only appears after the divider handed one over
    a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(div_valid))
        else $error("result word without a divider word");

    // the fade step never leaves the byte range of the red channel
    a_red_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid |-> (div_neg[0] && (div_q[0] <= div_base[0]))
                      || (!div_neg[0] && (({1'b0, div_base[0]} + {1'b0, div_q[0]}) <= 9'd255)))
        else $error("red channel fade left the byte range");

    // the fade step never leaves the byte range of the white channel
    a_white_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid |-> (div_neg[3] && (div_q[3] <= div_base[3]))
                      || (!div_neg[3] && (({1'b0, div_base[3]} + {1'b0, div_q[3]}) <= 9'd255)))
        else $error("white channel fade left the byte range");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W = lgp_pkg::IDX_W;
    localparam int CFG_W = lgp_pkg::CFG_W;
    localparam int PIPE_DRAIN = 20;
    localparam int STALL_LIMIT = 5000;
    localparam int REPORT_MAX = 10;
    localparam int HOLD_CYCLES = 300;
    // indexes past the last register, writes there must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } pixel_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              pixel_valid = 1'b0;
    logic              pixel_stall;
    logic [5:0]        pixel_offset = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [5:0]        led_index;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [7:0]        white_out;

    lgp_pkg::lgp_cfg_t gradient_cfg;
    pixel_word_t  expected_pixels[$];
    int           bad_words = 0;
    int           quiet_cycles = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           hold_reqs = 0;
    int           holds_served = 0;
    int           hold_left = 0;

    led_segment_gradient_pixel_core #(
        .MAX_LEDS(MAX_LEDS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel_offset(pixel_offset),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .led_index(led_index),
        .red_out(red_out),
        .green_out(green_out),
        .blue_out(blue_out),
        .white_out(white_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // round(n / 512), halves away from zero
    function automatic int round_div512(input int n);
        if (n >= 0)
            return (n + 256) / 512;
        return -((-n + 256) / 512);
    endfunction

    function automatic bit predict_pixel(input logic [5:0] offset, output pixel_word_t word);
        int steps;
        int absolute;
        int lo;
        int hi;
        int a;
        int b;
        int v;
        logic [7:0] rgbw [4];
        word = '0;
        steps = int'(gradient_cfg.seg_end) - int'(gradient_cfg.seg_begin);
        absolute = int'(gradient_cfg.seg_begin) + int'(offset);
        if (steps <= 0 || int'(offset) >= steps || absolute >= MAX_LEDS)
            return 1'b0;
        lo = round_div512(steps * (2 * int'(gradient_cfg.fade_center)
                                   - int'(gradient_cfg.fade_width)));
        hi = round_div512(steps * (2 * int'(gradient_cfg.fade_center)
                                   + int'(gradient_cfg.fade_width)));
        if (hi > steps)
            hi = steps;
        for (int ch = 0; ch < lgp_pkg::NUM_CH; ch++)
        begin
            a = int'(gradient_cfg.color_a[31 - 8 * ch -: 8]);
            b = int'(gradient_cfg.color_b[31 - 8 * ch -: 8]);
            // end color wins where both ends apply
            if (int'(offset) >= hi)
                v = b;
            else if (int'(offset) <= lo)
                v = a;
            else
                v = a + (b - a) * (int'(offset) - lo) / (hi - lo);
            rgbw[ch] = v[7:0];
        end
        word.led_index = absolute[5:0];
        word.red = rgbw[0];
        word.green = rgbw[1];
        word.blue = rgbw[2];
        word.white = rgbw[3];
        return 1'b1;
    endfunction

    // receiver: random stall, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pixel_word_t exp_word;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                bad_words++;
                if (bad_words <= REPORT_MAX)
                    $display("unexpected word at %0t: idx %0d rgbw %h %h %h %h", $time,
                             led_index, red_out, green_out, blue_out, white_out);
            end
            else
            begin
                exp_word = expected_pixels.pop_front();
                if (led_index !== exp_word.led_index || red_out !== exp_word.red
                    || green_out !== exp_word.green || blue_out !== exp_word.blue
                    || white_out !== exp_word.white)
                begin
                    bad_words++;
                    if (bad_words <= REPORT_MAX)
                        $display("mismatch at %0t: expected idx %0d rgbw %h %h %h %h, ",
                                 $time, exp_word.led_index, exp_word.red, exp_word.green,
                                 exp_word.blue, exp_word.white,
                                 "got idx %0d rgbw %h %h %h %h", led_index, red_out,
                                 green_out, blue_out, white_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // offers one word, returns once it is taken, queues its expected pixel
    task automatic send_pixel(input logic [5:0] offset, output bit has_result);
        pixel_word_t word;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_offset <= offset;
        do @(posedge clk); while (pixel_stall);
        has_result = predict_pixel(offset, word);
        if (has_result)
            expected_pixels.push_back(word);
    endtask

    task automatic send_offsets(input logic [5:0] offsets[]);
        bit has_result;
        foreach (offsets[i])
            send_pixel(offsets[i], has_result);
    endtask

    // let the pipe empty, including words that give no result
    task automatic drain_pipe();
        pixel_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            lgp_pkg::REG_SEG_BEGIN:   gradient_cfg.seg_begin = data[5:0];
            lgp_pkg::REG_SEG_END:     gradient_cfg.seg_end = data[6:0];
            lgp_pkg::REG_COLOR_A:     gradient_cfg.color_a = data;
            lgp_pkg::REG_COLOR_B:     gradient_cfg.color_b = data;
            lgp_pkg::REG_FADE_CENTER: gradient_cfg.fade_center = data[7:0];
            lgp_pkg::REG_FADE_WIDTH:  gradient_cfg.fade_width = data[7:0];
            default:                  ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_gradient(input logic [5:0] seg_begin, input logic [6:0] seg_end,
                                 input logic [31:0] color_a, input logic [31:0] color_b,
                                 input logic [7:0] center, input logic [7:0] width);
        drain_pipe();
        write_reg(lgp_pkg::REG_SEG_BEGIN, CFG_W'(seg_begin));
        write_reg(lgp_pkg::REG_SEG_END, CFG_W'(seg_end));
        write_reg(lgp_pkg::REG_COLOR_A, color_a);
        write_reg(lgp_pkg::REG_COLOR_B, color_b);
        write_reg(lgp_pkg::REG_FADE_CENTER, CFG_W'(center));
        write_reg(lgp_pkg::REG_FADE_WIDTH, CFG_W'(width));
    endtask

    task automatic test_reset_defaults();
        send_offsets('{6'd0, 6'd63});
    endtask

    task automatic test_fade_window();
        // window 28..36 over a full segment, every byte swings between 0 and 255
        load_gradient(6'd0, 7'd64, 32'hFF00FF00, 32'h00FF00FF, 8'd128, 8'd32);
        send_offsets('{6'd0, 6'd28, 6'd29, 6'd32, 6'd35, 6'd36, 6'd63});
        load_gradient(6'd0, 7'd64, 32'h00FF00FF, 32'hFF00FF00, 8'd128, 8'd255);
        send_offsets('{6'd1, 6'd62});
    endtask

    task automatic test_window_edges();
        // window starts below the segment
        load_gradient(6'd0, 7'd64, 32'h12345678, 32'hFEDCBA98, 8'd0, 8'd255);
        send_offsets('{6'd0, 6'd16, 6'd31});
        // window sits at the segment end, nothing inside the fade
        load_gradient(6'd0, 7'd64, 32'h11223344, 32'hAABBCCDD, 8'd255, 8'd0);
        send_offsets('{6'd10, 6'd63});
        // both ends apply at once
        load_gradient(6'd0, 7'd64, 32'h11223344, 32'hAABBCCDD, 8'd0, 8'd0);
        send_offsets('{6'd0, 6'd5});
    endtask

    task automatic test_segment_bounds();
        load_gradient(6'd10, 7'd20, 32'h00000000, 32'hFFFFFFFF, 8'd128, 8'd128);
        send_offsets('{6'd9, 6'd10});
        load_gradient(6'd40, 7'd10, 32'h00000000, 32'hFFFFFFFF, 8'd128, 8'd128);
        send_offsets('{6'd0});
        load_gradient(6'd30, 7'd30, 32'h00000000, 32'hFFFFFFFF, 8'd128, 8'd128);
        send_offsets('{6'd0});
        // segment runs past the strip
        load_gradient(6'd50, 7'd100, 32'h80808080, 32'h7F7F7F7F, 8'd64, 8'd200);
        send_offsets('{6'd13, 6'd14, 6'd63});
        load_gradient(6'd0, 7'd127, 32'hFFFFFFFF, 32'h00000000, 8'd255, 8'd255);
        send_offsets('{6'd63});
    endtask

    task automatic test_spare_index();
        drain_pipe();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        send_offsets('{6'd5});
    endtask

    task automatic random_gradient();
        logic [5:0] seg_begin;
        logic [6:0] seg_end;
        logic [7:0] center;
        logic [7:0] width;
        seg_begin = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
        if ($urandom_range(9) == 0)
            seg_end = 7'($urandom_range(127));
        else
            seg_end = 7'(int'(seg_begin) + $urandom_range(1, 127 - int'(seg_begin)));
        center = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                          : 8'($urandom_range(255));
        width = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                         : 8'($urandom_range(255));
        load_gradient(seg_begin, seg_end, $urandom, $urandom, center, width);
    endtask

    task automatic test_random_stream(input int tx_pct, input int rx_pct, input int pixels);
        int sent;
        int batch;
        int steps;
        bit has_result;
        logic [5:0] offset;
        sent = 0;
        drain_pipe();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < pixels)
        begin
            random_gradient();
            steps = int'(gradient_cfg.seg_end) - int'(gradient_cfg.seg_begin);
            batch = $urandom_range(30, 90);
            for (int i = 0; i < batch && sent < pixels; i++)
            begin
                // mostly offsets inside the segment, some anywhere
                if (steps > 0 && $urandom_range(7) != 0)
                    offset = 6'($urandom_range((steps > 64 ? 64 : steps) - 1));
                else
                    offset = 6'($urandom_range(63));
                send_pixel(offset, has_result);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        bit has_result;
        load_gradient(6'd0, 7'd64, $urandom, $urandom, 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_reqs++;
        for (int i = 0; i < 60; i++)
            send_pixel(6'($urandom_range(63)), has_result);
    endtask

    initial
    begin
        gradient_cfg.seg_begin = 6'd0;
        gradient_cfg.seg_end = 7'd64;
        gradient_cfg.color_a = 32'd0;
        gradient_cfg.color_b = 32'd0;
        gradient_cfg.fade_center = 8'd128;
        gradient_cfg.fade_width = 8'd32;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 8;
        rx_idle_pct = 79;
        test_reset_defaults();
        test_fade_window();
        test_window_edges();
        test_segment_bounds();
        test_spare_index();

        test_random_stream(8, 79, 600);
        test_random_stream(79, 8, 600);
        test_random_stream(0, 0, 600);
        test_backpressure();

        drain_pipe();
        if (bad_words == 0 && expected_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
